@@ src/nlb_pkg.sv @@
// nlb_pkg: shared types and constants for the newline line buffer
// no dependencies; imported by every module of the block but nlb_ram

package nlb_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CFG_W     = 7;
  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_BYTE       = 3'd2,
    ST_EMPTY_LINE = 3'd3,
    ST_NO_LINE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_ADDED,
    CMD_REJECT,
    CMD_LINE,
    CMD_DRAIN,
    CMD_NOLINE
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_CHECK
  } bstate_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_in;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    logic       last;
  } rsp_t;

  typedef struct packed {
    cmd_t cmd;
  } qent_t;

  // back end to front end bookkeeping during a line removal
  typedef struct packed {
    logic byte_taken;
    logic newline_taken;
    logic done;
  } fb_t;

endpackage

@@ src/nlb_ram.sv @@
// nlb_ram: generic simple dual-port ram, one write port, one registered read port
// no package dependencies

module nlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/nlb_queue.sv @@
// nlb_queue: two-entry command queue between the front and back ends
// depends on nlb_pkg for the entry type

module nlb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nlb_pkg::qent_t wdata,
  output logic          full,
  input  logic          pop,
  output nlb_pkg::qent_t rdata,
  output logic          empty
);
  import nlb_pkg::*;

  qent_t      ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= wdata;
    end
  end

endmodule

@@ src/nlb_front.sv @@
// nlb_front: request intake, capacity register, byte writes and command classification
// depends on nlb_pkg; feeds nlb_queue and the write port of nlb_ram

module nlb_front #(
  parameter int DEPTH = nlb_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  nlb_pkg::req_t                  req,
  input  logic                           capacity_we,
  input  logic [nlb_pkg::CFG_W-1:0]      capacity_data,
  output logic                           q_push,
  input  logic                           q_full,
  output nlb_pkg::qent_t                 q_wdata,
  output logic                           mem_we,
  output logic [$clog2(DEPTH)-1:0]       mem_waddr,
  output logic [7:0]                     mem_wdata,
  input  nlb_pkg::fb_t                   fb,
  output logic [$clog2(DEPTH):0]         cap
);
  import nlb_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CAP_W = AW + 1;

  logic [AW-1:0]    tail;
  logic [CAP_W-1:0] fill;
  logic [CAP_W-1:0] nl_count;
  logic             busy;

  logic             accept;
  logic             is_full;
  cmd_t             cmd;
  logic [CAP_W-1:0] tail_inc;
  logic [AW-1:0]    tail_adv;
  logic [CAP_W-1:0] cap_clamped;

  assign req_ready = !busy && !q_full;
  assign accept    = req_valid && req_ready;
  assign is_full   = (fill >= cap);
  assign tail_inc  = {1'b0, tail} + CAP_W'(1);
  assign tail_adv  = (tail_inc >= cap) ? '0 : tail_inc[AW-1:0];

  always_comb begin
    if (capacity_data < CFG_W'(2)) begin
      cap_clamped = CAP_W'(2);
    end else if (capacity_data > CFG_W'(DEPTH)) begin
      cap_clamped = CAP_W'(DEPTH);
    end else begin
      cap_clamped = capacity_data[CAP_W-1:0];
    end
  end

  always_comb begin
    priority if (req.operation == OP_ADD) begin
      cmd = is_full ? CMD_REJECT : CMD_ADDED;
    end else if (nl_count != '0 && fill != '0) begin
      cmd = CMD_LINE;
    end else if (is_full) begin
      cmd = CMD_DRAIN;
    end else begin
      cmd = CMD_NOLINE;
    end
  end

  assign q_push      = accept;
  assign q_wdata.cmd = cmd;
  assign mem_we      = accept && (cmd == CMD_ADDED);
  assign mem_waddr   = tail;
  assign mem_wdata   = req.data_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      tail     <= '0;
      fill     <= '0;
      nl_count <= '0;
      busy     <= 1'b0;
      cap      <= CAP_W'(DEPTH);
    end else if (capacity_we) begin
      tail     <= '0;
      fill     <= '0;
      nl_count <= '0;
      busy     <= 1'b0;
      cap      <= cap_clamped;
    end else if (accept) begin
      unique case (cmd)
        CMD_ADDED: begin
          tail <= tail_adv;
          fill <= fill + CAP_W'(1);
          if (req.data_in == NEWLINE) begin
            nl_count <= nl_count + CAP_W'(1);
          end
        end
        CMD_LINE: begin
          busy <= 1'b1;
        end
        // full store without newline: all but one stored byte go out, counts drop at once
        CMD_DRAIN: begin
          busy     <= 1'b1;
          fill     <= '0;
          nl_count <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      if (fb.done) begin
        busy <= 1'b0;
      end
      if (fb.byte_taken) begin
        fill <= fill - CAP_W'(1);
      end
      if (fb.newline_taken) begin
        nl_count <= nl_count - CAP_W'(1);
      end
    end
  end

endmodule

@@ src/nlb_back.sv @@
// nlb_back: executes queued commands, reads line bytes and drives the result register
// depends on nlb_pkg; reads through the registered port of nlb_ram

module nlb_back #(
  parameter int DEPTH = nlb_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     capacity_we,
  input  logic [$clog2(DEPTH):0]   cap,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  nlb_pkg::qent_t           q_rdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [7:0]               mem_rdata,
  output nlb_pkg::fb_t             fb,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output nlb_pkg::rsp_t            rsp
);
  import nlb_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CAP_W = AW + 1;

  bstate_t          state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [7:0]       pend, pend_next;
  logic             has_pend, has_pend_next;
  logic             is_drain, is_drain_next;
  logic [CAP_W-1:0] cnt, cnt_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic             out_free;
  logic [CAP_W-1:0] ptr_inc;
  logic [AW-1:0]    ptr_adv;
  logic             drain_last;

  assign out_free   = !rsp_valid || rsp_ready;
  assign ptr_inc    = {1'b0, ptr} + CAP_W'(1);
  assign ptr_adv    = (ptr_inc >= cap) ? '0 : ptr_inc[AW-1:0];
  assign drain_last = (cnt == cap - CAP_W'(2));
  assign mem_raddr  = ptr;

  always_ff @(posedge clk) begin
    if (rst || capacity_we) begin
      state     <= B_IDLE;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    pend     <= pend_next;
    has_pend <= has_pend_next;
    is_drain <= is_drain_next;
    cnt      <= cnt_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    ptr_next       = ptr;
    pend_next      = pend;
    has_pend_next  = has_pend;
    is_drain_next  = is_drain;
    cnt_next       = cnt;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    fb             = '0;

    unique case (state)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop         = 1'b1;
          ptr_next      = head;
          has_pend_next = 1'b0;
          cnt_next      = '0;
          unique case (q_rdata.cmd)
            CMD_ADDED: begin
              rsp_valid_next = 1'b1;
              rsp_next       = '{status: ST_ADDED, data_out: 8'd0, last: 1'b1};
            end
            CMD_REJECT: begin
              rsp_valid_next = 1'b1;
              rsp_next       = '{status: ST_FULL, data_out: 8'd0, last: 1'b1};
            end
            CMD_NOLINE: begin
              rsp_valid_next = 1'b1;
              rsp_next       = '{status: ST_NO_LINE, data_out: 8'd0, last: 1'b1};
            end
            CMD_LINE: begin
              is_drain_next = 1'b0;
              state_next    = B_ISSUE;
            end
            CMD_DRAIN: begin
              is_drain_next = 1'b1;
              state_next    = B_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end

      B_ISSUE: begin
        mem_re     = 1'b1;
        state_next = B_CHECK;
      end

      B_CHECK: begin
        priority if (is_drain) begin
          if (out_free) begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{status: ST_BYTE, data_out: mem_rdata, last: drain_last};
            ptr_next       = ptr_adv;
            cnt_next       = cnt + CAP_W'(1);
            if (drain_last) begin
              fb.done    = 1'b1;
              state_next = B_IDLE;
            end else begin
              state_next = B_ISSUE;
            end
          end
        end else if (mem_rdata == NEWLINE) begin
          // the held byte, if any, closes the line
          if (out_free) begin
            rsp_valid_next = 1'b1;
            if (has_pend) begin
              rsp_next = '{status: ST_BYTE, data_out: pend, last: 1'b1};
            end else begin
              rsp_next = '{status: ST_EMPTY_LINE, data_out: 8'd0, last: 1'b1};
            end
            head_next        = ptr_adv;
            fb.byte_taken    = 1'b1;
            fb.newline_taken = 1'b1;
            fb.done          = 1'b1;
            state_next       = B_IDLE;
          end
        end else if (!has_pend || out_free) begin
          // hold one byte back until we know whether it ends the line
          if (has_pend) begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{status: ST_BYTE, data_out: pend, last: 1'b0};
          end
          pend_next     = mem_rdata;
          has_pend_next = 1'b1;
          ptr_next      = ptr_adv;
          fb.byte_taken = 1'b1;
          state_next    = B_ISSUE;
        end else begin
          // a byte is held and the output is stalled: wait here
        end
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

endmodule

@@ src/newline_line_buffer_top.sv @@
// Newline-delimited line buffer. A front end takes one request beat per cycle while its
// two-entry command queue has room: an add (or a rejected add, or a remove that finds no
// line) gives a single result, which passes through the command queue into the output
// register when the back end is idle and the consumer keeps up. A remove that hands out
// a line, or drains a full store without a newline, pauses intake until the last beat of
// the line is loaded into the output register; the back end picks up the command and
// then reads the byte store through its single registered read port, each stored byte of
// the line, the newline included, in an address state and then a data state, plus the
// wait for the consumer. The store needs no clearing after reset; writing the capacity
// empties the buffer at once.
//
// top level: instantiates nlb_front, nlb_queue, nlb_back and nlb_ram; depends on nlb_pkg

module newline_line_buffer_top #(
  parameter int DEPTH = nlb_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  nlb_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output nlb_pkg::rsp_t             rsp,
  input  logic                      capacity_we,
  input  logic [nlb_pkg::CFG_W-1:0] capacity_data
);
  import nlb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  qent_t         q_wdata;
  qent_t         q_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  fb_t           fb;
  logic [AW:0]   cap;

  nlb_front #(.DEPTH(DEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_wdata       (q_wdata),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .fb            (fb),
    .cap           (cap)
  );

  nlb_queue u_queue (
    .clk   (clk),
    .rst   (rst || capacity_we),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  nlb_back #(.DEPTH(DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .capacity_we (capacity_we),
    .cap         (cap),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_rdata     (q_rdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .fb          (fb),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

  nlb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ src/nlb_checker.sv @@
// nlb_checker: port-level assertions for the newline line buffer, bound to the top level
// depends on nlb_pkg for the result type and status codes

module nlb_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input nlb_pkg::rsp_t rsp
);
  import nlb_pkg::*;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // only line bytes carry data
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_BYTE |-> rsp.data_out == 8'd0)
    else $error("nonzero data on a non-byte result");

  // every non-byte status is the sole result of its request
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_ADDED || rsp.status == ST_FULL ||
                  rsp.status == ST_EMPTY_LINE || rsp.status == ST_NO_LINE)
    |-> rsp.last)
    else $error("single-result status without last");

endmodule

bind newline_line_buffer_top nlb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
